>>> src/great_circle_distance_macros.svh
// Assertion macros shared by the great circle distance RTL.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/gcd_pkg.sv
// Constants, types and helper functions of the great circle distance block.
package gcd_pkg;

	localparam int CORDIC_ITERATIONS = 20;
	// Input register, angle reduction, scaling, rotation, four product stages,
	// 31 square root stages, vectoring, three output stages.
	localparam int LATENCY = 41 + 2 * CORDIC_ITERATIONS;

	localparam int W_LAT = 24;
	localparam int W_LON = 25;
	localparam int W_DIST = 22;
	localparam int W_RAD = 16;
	localparam int W_CR = 34;

	localparam logic [W_RAD-1:0] RADIUS_RESET = 16'd3960;

	localparam logic signed [26:0] DEG_FULL = 27'sd23592960;
	localparam logic signed [26:0] DEG_HALF = 27'sd11796480;
	localparam logic signed [26:0] DEG_QUARTER = 27'sd5898240;
	localparam logic [26:0] RAD_PER_DEG = 27'd74961321;
	localparam logic signed [W_CR-1:0] GAIN_INV = 34'sd652032874;
	localparam logic signed [W_CR:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [W_CR:0] ONE_Q30 = 35'sd1073741824;
	localparam logic [W_DIST-1:0] DIST_MAX = 22'd3294192;

	typedef struct packed {
		logic signed [W_LAT-1:0] r;
		logic flip;
	} red_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Reduce an angle into (-180,180] and fold it into [-90,90].
	function automatic red_t reduce_deg(input logic signed [25:0] d);
		logic signed [26:0] t;
		red_t o;
		t = 27'(d);
		if (t > DEG_HALF) begin
			t = t - DEG_FULL;
		end else if (t <= -DEG_HALF) begin
			t = t + DEG_FULL;
		end
		o.flip = 1'b0;
		if (t > DEG_QUARTER) begin
			t = DEG_HALF - t;
			o.flip = 1'b1;
		end else if (t < -DEG_QUARTER) begin
			t = -DEG_HALF - t;
			o.flip = 1'b1;
		end
		o.r = t[W_LAT-1:0];
		return o;
	endfunction

	// Rounded Q30 product with a floor shift.
	function automatic logic signed [W_CR-1:0] mul_q30(input logic signed [W_CR-1:0] a,
			input logic signed [W_CR-1:0] b);
		logic signed [2*W_CR-1:0] p;
		p = a * b + 68'sd536870912;
		return p[W_CR+29:30];
	endfunction

endpackage

>>> src/great_circle_distance.sv
// Throughput: one item per cycle unless held; every stage is a register and the chain moves as one.
// The chain holds while the output register is full and stalled.
// Reset clears all valid bits and sets the radius register to 3960.
`include "great_circle_distance_macros.svh"

module great_circle_distance (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [gcd_pkg::W_LAT-1:0] first_latitude,
	input logic signed [gcd_pkg::W_LON-1:0] first_longitude,
	input logic signed [gcd_pkg::W_LAT-1:0] second_latitude,
	input logic signed [gcd_pkg::W_LON-1:0] second_longitude,
	output logic out_valid,
	input logic out_stall,
	output logic [gcd_pkg::W_DIST-1:0] distance,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gcd_pkg::W_RAD-1:0] sphere_radius
);
	import gcd_pkg::*;

	localparam int N = CORDIC_ITERATIONS;
	localparam int V_M3 = 5 + N;
	localparam int V_A1 = 38 + 2 * N;

	logic [LATENCY-1:0] vld_q;
	logic adv;
	logic [W_RAD-1:0] radius_q;

	// The whole chain advances unless a finished result is held at the output.
	assign adv = !vld_q[LATENCY-1] || !out_stall;
	assign in_stall = !adv;
	assign out_valid = vld_q[LATENCY-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LATENCY-2:0], in_valid};
		end
	end

	// Radius register, written by a configuration transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= sphere_radius;
		end
	end

	// Input registers and longitude difference.
	logic signed [25:0] ang_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[0] <= 26'(first_latitude);
			ang_s1[1] <= 26'(second_latitude);
			ang_s1[2] <= 26'(first_longitude) - 26'(second_longitude);
		end
	end

	// Three lanes: latitude one, latitude two, longitude difference.
	logic signed [W_LAT-1:0] red_s2 [3];
	logic flip_s2 [3];
	logic [49:0] prod_s3 [3];
	logic neg_s3 [3];
	logic flip_s3 [3];
	logic signed [W_CR-1:0] rx_s [N][3];
	logic signed [W_CR-1:0] ry_s [N][3];
	logic signed [W_CR-1:0] rz_s [N][3];
	logic rflip_s [N][3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		red_t red;
		logic [W_LAT-2:0] mag;
		logic [31:0] zr;
		logic signed [W_CR-1:0] z0;

		assign red = reduce_deg(ang_s1[l]);
		assign mag = (W_LAT-1)'(red_s2[l] < 0 ? -red_s2[l] : red_s2[l]);
		assign zr = 32'((prod_s3[l] + 50'd131072) >> 18);
		assign z0 = neg_s3[l] ? -$signed({2'b00, zr}) : $signed({2'b00, zr});

		// Angle reduction, then degrees to radians.
		always_ff @(posedge clk) begin
			if (adv) begin
				red_s2[l] <= red.r;
				flip_s2[l] <= red.flip;
				prod_s3[l] <= 50'(mag) * 50'(RAD_PER_DEG);
				neg_s3[l] <= red_s2[l] < 0;
				flip_s3[l] <= flip_s2[l];
			end
		end

		// Rotation CORDIC, one iteration per stage.
		for (genvar k = 0; k < N; k++) begin : g_rot
			logic signed [W_CR-1:0] xi, yi, zi;
			logic fi;
			logic signed [W_CR-1:0] at;
			if (k == 0) begin : g_first
				assign xi = GAIN_INV;
				assign yi = '0;
				assign zi = z0;
				assign fi = flip_s3[l];
			end else begin : g_next
				assign xi = rx_s[k-1][l];
				assign yi = ry_s[k-1][l];
				assign zi = rz_s[k-1][l];
				assign fi = rflip_s[k-1][l];
			end
			assign at = $signed({2'b00, atan_q30(5'(k))});
			always_ff @(posedge clk) begin
				if (adv) begin
					rflip_s[k][l] <= fi;
					if (zi >= 0) begin
						rx_s[k][l] <= xi - (yi >>> k);
						ry_s[k][l] <= yi + (xi >>> k);
						rz_s[k][l] <= zi - at;
					end else begin
						rx_s[k][l] <= xi + (yi >>> k);
						ry_s[k][l] <= yi - (xi >>> k);
						rz_s[k][l] <= zi + at;
					end
				end
			end
		end
	end

	// Cosine of each lane, negated where the angle was folded.
	logic signed [W_CR-1:0] cos_v [3];
	for (genvar l = 0; l < 3; l++) begin : g_cos
		assign cos_v[l] = rflip_s[N-1][l] ? -rx_s[N-1][l] : rx_s[N-1][l];
	end

	// Products of the law of cosines and the clamped cosine.
	logic signed [W_CR-1:0] p1_m1, p2_m1, cd_m1, p1_m2, p3_m2;
	logic signed [W_CR:0] csum;
	logic signed [31:0] c_m3;
	logic [30:0] cmag;
	logic [60:0] rem_m4;
	logic [30:0] cmag_m4;
	logic cneg_m4;

	assign csum = 35'(p1_m2) + 35'(p3_m2);
	assign cmag = 31'(c_m3 < 0 ? -c_m3 : c_m3);

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_m1 <= mul_q30(ry_s[N-1][0], ry_s[N-1][1]);
			p2_m1 <= mul_q30(cos_v[0], cos_v[1]);
			cd_m1 <= cos_v[2];
			p1_m2 <= p1_m1;
			p3_m2 <= mul_q30(p2_m1, cd_m1);
			if (csum > ONE_Q30) begin
				c_m3 <= 32'(ONE_Q30);
			end else if (csum < -ONE_Q30) begin
				c_m3 <= 32'(-ONE_Q30);
			end else begin
				c_m3 <= 32'(csum);
			end
			rem_m4 <= (61'd1 << 60) - 61'(62'(cmag) * 62'(cmag));
			cmag_m4 <= cmag;
			cneg_m4 <= c_m3 < 0;
		end
	end

	// Square root, one result bit per stage.
	logic [60:0] sv_s [31];
	logic [61:0] sr_s [31];
	logic [30:0] scm_s [31];
	logic sneg_s [31];

	for (genvar j = 0; j < 31; j++) begin : g_sqrt
		logic [60:0] vi;
		logic [61:0] ri, trial;
		logic [30:0] cmi;
		logic ni;
		if (j == 0) begin : g_first
			assign vi = rem_m4;
			assign ri = '0;
			assign cmi = cmag_m4;
			assign ni = cneg_m4;
		end else begin : g_next
			assign vi = sv_s[j-1];
			assign ri = sr_s[j-1];
			assign cmi = scm_s[j-1];
			assign ni = sneg_s[j-1];
		end
		assign trial = ri + (62'd1 << (2 * (30 - j)));
		always_ff @(posedge clk) begin
			if (adv) begin
				scm_s[j] <= cmi;
				sneg_s[j] <= ni;
				if ({1'b0, vi} >= trial) begin
					sv_s[j] <= vi - 61'(trial);
					sr_s[j] <= (ri >> 1) + (62'd1 << (2 * (30 - j)));
				end else begin
					sv_s[j] <= vi;
					sr_s[j] <= ri >> 1;
				end
			end
		end
	end

	// Vectoring CORDIC for the arccosine, one iteration per stage.
	logic signed [W_CR-1:0] vx_s [N];
	logic signed [W_CR-1:0] vy_s [N];
	logic signed [W_CR-1:0] vt_s [N];
	logic vneg_s [N];

	for (genvar k = 0; k < N; k++) begin : g_vec
		logic signed [W_CR-1:0] xi, yi, ti, at;
		logic ni;
		if (k == 0) begin : g_first
			assign xi = $signed({3'b000, scm_s[30]});
			assign yi = $signed({3'b000, sr_s[30][30:0]});
			assign ti = '0;
			assign ni = sneg_s[30];
		end else begin : g_next
			assign xi = vx_s[k-1];
			assign yi = vy_s[k-1];
			assign ti = vt_s[k-1];
			assign ni = vneg_s[k-1];
		end
		assign at = $signed({2'b00, atan_q30(5'(k))});
		always_ff @(posedge clk) begin
			if (adv) begin
				vneg_s[k] <= ni;
				if (yi > 0) begin
					vx_s[k] <= xi + (yi >>> k);
					vy_s[k] <= yi - (xi >>> k);
					vt_s[k] <= ti + at;
				end else begin
					vx_s[k] <= xi - (yi >>> k);
					vy_s[k] <= yi + (xi >>> k);
					vt_s[k] <= ti - at;
				end
			end
		end
	end

	// Angle over the full half turn, clamped, then scaled by the radius.
	logic signed [W_CR:0] ang;
	logic [31:0] ang_a1;
	logic [47:0] prod_a2;

	assign ang = vneg_s[N-1] ? PI_Q30 - 35'(vt_s[N-1]) : 35'(vt_s[N-1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ang < 0) begin
				ang_a1 <= '0;
			end else if (ang > PI_Q30) begin
				ang_a1 <= 32'(PI_Q30);
			end else begin
				ang_a1 <= 32'(ang);
			end
			prod_a2 <= 48'(ang_a1) * 48'(radius_q);
			distance <= W_DIST'((prod_a2 + 48'd33554432) >> 26);
		end
	end

	`GCD_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld_q[0], "accepted item lost at entry")
	`GCD_ASSERT_NEXT(a_hold, !adv, vld_q == $past(vld_q), "pipeline moved while held")
	`GCD_ASSERT_NOW(a_clamp, vld_q[V_M3], c_m3 <= 32'sd1073741824 && c_m3 >= -32'sd1073741824, "cosine out of range")
	`GCD_ASSERT_NOW(a_range, out_valid, distance <= DIST_MAX, "distance beyond half circumference")
	`GCD_ASSERT_NOW(a_angle, vld_q[V_A1], ang_a1 <= 32'd3373259426, "angle beyond pi")

endmodule

>>> dv/tb_great_circle_distance.sv
// Self-checking testbench for the great circle distance pipeline.
`timescale 1ns / 100ps

module tb_great_circle_distance;
	import gcd_pkg::*;

	localparam longint DEG_FULL_Q16 = 23592960;
	localparam longint DEG_HALF_Q16 = 11796480;
	localparam longint DEG_QTR_Q16 = 5898240;
	localparam longint ONE_Q30_L = 64'sd1073741824;
	localparam longint PI_Q30_L = 64'sd3373259426;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASE_ITEMS = 300;

	// One row of the directed stimulus; the expected distance is used only when typed in.
	typedef struct {
		int radius;
		int lat_a;
		int lon_a;
		int lat_b;
		int lon_b;
		bit typed;
		int want_dist;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [W_LAT-1:0] first_latitude;
	logic signed [W_LON-1:0] first_longitude;
	logic signed [W_LAT-1:0] second_latitude;
	logic signed [W_LON-1:0] second_longitude;
	logic out_valid;
	logic out_stall;
	logic [W_DIST-1:0] distance;
	logic cfg_valid;
	logic cfg_ready;
	logic [W_RAD-1:0] sphere_radius;

	longint atan_tab [32];
	logic [W_RAD-1:0] radius_now;
	logic [W_DIST-1:0] dist_q [$];
	bit typed_q [$];
	logic [W_DIST-1:0] typed_dist_q [$];
	int errors;
	int out_wait;
	bit out_calm;
	bit row_typed;
	logic [W_DIST-1:0] row_dist;

	great_circle_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_latitude(first_latitude),
		.first_longitude(first_longitude),
		.second_latitude(second_latitude),
		.second_longitude(second_longitude),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sphere_radius(sphere_radius)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Sine and cosine in Q30 of an angle in Q16 degrees, by CORDIC rotation.
	task automatic rotate_deg(input longint deg, output longint sv, output longint cv);
		longint r, m, z, x, y, dx, dy;
		bit flip;
		r = deg % DEG_FULL_Q16;
		flip = 0;
		if (r < 0) r += DEG_FULL_Q16;
		if (r > DEG_HALF_Q16) r -= DEG_FULL_Q16;
		if (r > DEG_QTR_Q16) begin
			r = DEG_HALF_Q16 - r;
			flip = 1;
		end else if (r < -DEG_QTR_Q16) begin
			r = -DEG_HALF_Q16 - r;
			flip = 1;
		end
		m = (r < 0) ? -r : r;
		z = (m * 74961321 + (64'sd1 << 17)) >>> 18;
		if (r < 0) z = -z;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i & 31];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i & 31];
			end
		end
		sv = y;
		cv = flip ? -x : x;
	endtask

	function automatic longint q30_product(input longint a, input longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Expected distance in sixteenths of a mile for one pair of locations.
	task automatic gc_distance_of(input longint lat1, input longint lon1, input longint lat2,
			input longint lon2, input logic [W_RAD-1:0] radius,
			output logic [W_DIST-1:0] dist_out);
		longint s1, c1, s2, c2, sd, cd, c, x, y, t, ang, dx, dy;
		longint unsigned s, prod;
		rotate_deg(lat1, s1, c1);
		rotate_deg(lat2, s2, c2);
		rotate_deg(lon1 - lon2, sd, cd);
		c = q30_product(s1, s2) + q30_product(q30_product(c1, c2), cd);
		if (c > ONE_Q30_L) c = ONE_Q30_L;
		if (c < -ONE_Q30_L) c = -ONE_Q30_L;
		s = root_floor(longint'(ONE_Q30_L * ONE_Q30_L) - c * c);
		// Vectoring CORDIC on (|c|, s) gives the angle from the cosine.
		x = (c < 0) ? -c : c;
		y = longint'(s);
		t = 0;
		for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				t += atan_tab[i & 31];
			end else begin
				x -= dx;
				y += dy;
				t -= atan_tab[i & 31];
			end
		end
		ang = (c < 0) ? PI_Q30_L - t : t;
		if (ang < 0) ang = 0;
		if (ang > PI_Q30_L) ang = PI_Q30_L;
		prod = ($unsigned(ang) * radius + (64'd1 << 25)) >> 26;
		dist_out = prod[W_DIST-1:0];
	endtask

	// Predict every input transfer as it is taken.
	always @(posedge clk) begin
		logic [W_DIST-1:0] d;
		if (arst_n && in_valid && !in_stall) begin
			gc_distance_of(first_latitude, first_longitude, second_latitude, second_longitude,
				radius_now, d);
			dist_q.push_back(d);
			typed_q.push_back(row_typed);
			typed_dist_q.push_back(row_dist);
		end
	end

	// Check each output transfer and pace the output stall.
	always @(posedge clk) begin
		logic [W_DIST-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (dist_q.size() == 0) begin
					report_mismatch($sformatf("unexpected distance %0d", distance));
				end else begin
					want = dist_q.pop_front();
					if (distance !== want)
						report_mismatch($sformatf("distance %0d, predicted %0d", distance, want));
					if (typed_q.pop_front() && distance !== typed_dist_q[0])
						report_mismatch($sformatf("distance %0d, table says %0d", distance,
							typed_dist_q[0]));
					void'(typed_dist_q.pop_front());
				end
				out_wait = out_calm ? 0 : $urandom_range(0, 11);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait > 0);
		end
	end

	task automatic send_pair(input int lat_a, input int lon_a, input int lat_b, input int lon_b,
			input bit calm);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_latitude <= lat_a[W_LAT-1:0];
		first_longitude <= lon_a[W_LON-1:0];
		second_latitude <= lat_b[W_LAT-1:0];
		second_longitude <= lon_b[W_LON-1:0];
		do @(posedge clk); while (in_stall);
	endtask

	// Let the pipeline empty, then write the radius.
	task automatic set_radius(input int value);
		in_valid <= 1'b0;
		// Wait so that the last input transfer is already predicted.
		@(posedge clk);
		while (dist_q.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		sphere_radius <= value[W_RAD-1:0];
		do @(posedge clk); while (!cfg_ready);
		radius_now = value[W_RAD-1:0];
		cfg_valid <= 1'b0;
	endtask

	function automatic int span(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	initial begin
		dir_row_t dir_tab [];
		int lat_a, lon_a, lat_b, lon_b, kind;
		int radii [6];
		bit calm;
		atan_tab = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001, 64'h00000000};
		// Same points, antipodes, poles, range edges, wrap across the date line,
		// coordinates past their ranges and the radius extremes, zero included.
		dir_tab = '{
			'{3960, 0, 0, 0, 0, 0, 0},
			'{3960, 0, 0, 0, 1, 0, 0},
			'{3960, 0, 0, 0, LON_MAX, 0, 0},
			'{3960, LAT_MAX, 0, -LAT_MAX, 0, 0, 0},
			'{3960, 2949120, -5898240, 2949120, -5898240, 0, 0},
			'{3960, LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 0, 0},
			'{3960, -LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, 0, 0},
			'{3960, 0, 11795825, 0, -11795825, 0, 0},
			'{3960, 8388607, 16777215, -8388608, -16777216, 0, 0},
			'{3960, -8388608, -16777216, 8388607, 16777215, 0, 0},
			'{3960, 2621440, 5242880, -2621440, -6553600, 0, 0},
			'{65535, 0, 0, 0, LON_MAX, 0, 0},
			'{65535, LAT_MAX, 0, -LAT_MAX, 0, 0, 0},
			'{65535, 1234567, -7654321, 1234567, -7654321, 0, 0},
			'{65535, -3000000, 9000000, 4000000, -2000000, 0, 0},
			'{1, 0, 0, 0, LON_MAX, 0, 0},
			'{1, 0, 0, 65536, 0, 0, 0},
			'{0, 0, 0, 0, LON_MAX, 1, 0},
			'{0, LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 1, 0},
			'{0, 8388607, 16777215, -8388608, -16777216, 1, 0},
			'{0, 0, 0, 0, 0, 1, 0}
		};
		radii = '{65535, 1, 3960, 0, 0, 0};
		radii[3] = $urandom_range(2, 65534);
		radii[4] = $urandom_range(1, 255);
		radii[5] = 3960;
		errors = 0;
		radius_now = RADIUS_RESET;
		row_typed = 0;
		row_dist = '0;
		out_calm = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		sphere_radius = '0;
		first_latitude = '0;
		first_longitude = '0;
		second_latitude = '0;
		second_longitude = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows, in table order; the row marks change after the edge they were taken at.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].radius != radius_now) set_radius(dir_tab[i].radius);
			row_typed <= dir_tab[i].typed;
			row_dist <= dir_tab[i].want_dist[W_DIST-1:0];
			send_pair(dir_tab[i].lat_a, dir_tab[i].lon_a, dir_tab[i].lat_b, dir_tab[i].lon_b,
				i % 4 == 0);
		end
		row_typed <= 0;

		// Random phases, one radius each, with calm stretches on either side.
		for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
			set_radius(radii[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					out_calm = ($urandom_range(0, 3) == 0);
				end
				kind = $urandom_range(0, 19);
				lat_a = span(LAT_MAX);
				lon_a = span(LON_MAX);
				lat_b = span(LAT_MAX);
				lon_b = span(LON_MAX);
				if (kind == 0) begin
					lat_b = lat_a;
					lon_b = lon_a;
				end else if (kind == 1) begin
					lat_b = -lat_a;
					lon_b = (lon_a > 0) ? lon_a - LON_MAX : lon_a + LON_MAX;
				end else if (kind == 2) begin
					lat_b = lat_a + span(64);
					lon_b = lon_a + span(64);
				end else if (kind >= 17) begin
					lat_a = $urandom;
					lon_a = $urandom;
					lat_b = $urandom;
					lon_b = $urandom;
				end
				send_pair(lat_a, lon_a, lat_b, lon_b, calm);
			end
		end
		in_valid <= 1'b0;
		out_calm = 0;

		@(posedge clk);
		while (dist_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && dist_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> great_circle_distance.f
+incdir+src
src/gcd_pkg.sv
src/great_circle_distance.sv
dv/tb_great_circle_distance.sv
